// File: hdl/fsbb_pkg.sv
`timescale 1ns / 1ps
package fsbb_pkg;

	localparam int FUNC_W    = 2;
	localparam int KEY_W     = 64;
	localparam int SIZE_W    = 32;
	localparam int HANDLE_W  = 32;
	localparam int KIND_W    = 3;
	localparam int ENTRIES_W = 5;
	localparam int BYTES_W   = 34;
	localparam int COST_W    = 33;
	localparam int BUDGET_W  = 32;
	localparam int OVH_W     = 12;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DAT_W = 32;

	// operation codes
	localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_EVICT      = 3'd0;
	localparam logic [KIND_W-1:0] KIND_ADD_DONE   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_ADD_REJECT = 3'd2;
	localparam logic [KIND_W-1:0] KIND_HIT        = 3'd3;
	localparam logic [KIND_W-1:0] KIND_MISS       = 3'd4;
	localparam logic [KIND_W-1:0] KIND_CLEAR_DONE = 3'd5;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BYTE_BUDGET    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_OVERHEAD = 4'd1;

	localparam logic [BUDGET_W-1:0] BUDGET_RST = 32'd1048576;
	localparam logic [OVH_W-1:0]    OVH_RST    = 12'd64;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_PLAN  = 5'b00010,
		ST_EMIT  = 5'b00100,
		ST_SCAN  = 5'b01000,
		ST_FINAL = 5'b10000
	} state_t;

endpackage

// File: hdl/fsbb_cmd_if.sv
`timescale 1ns / 1ps
interface fsbb_cmd_if import fsbb_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [KEY_W-1:0]    key;
	logic [SIZE_W-1:0]   size_bytes;
	logic [HANDLE_W-1:0] handle;

	modport source (output valid, func, key, size_bytes, handle, input ready);
	modport sink   (input valid, func, key, size_bytes, handle, output ready);
endinterface

// File: hdl/fsbb_rsp_if.sv
`timescale 1ns / 1ps
interface fsbb_rsp_if import fsbb_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [KIND_W-1:0]    kind;
	logic [HANDLE_W-1:0]  out_handle;
	logic                 last;
	logic [ENTRIES_W-1:0] entries_held;
	logic [BYTES_W-1:0]   bytes_held;

	modport source (output valid, kind, out_handle, last, entries_held, bytes_held,
		input ready);
	modport sink   (input valid, kind, out_handle, last, entries_held, bytes_held,
		output ready);
endinterface

// File: hdl/fsbb_cfg_if.sv
`timescale 1ns / 1ps
interface fsbb_cfg_if import fsbb_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/fsbb_ram.sv
`timescale 1ns / 1ps
module fsbb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/fifo_store_byte_budget_lookup.sv
`timescale 1ns / 1ps
// FIFO response store with an entry limit and a byte budget.
// Channels: cfg writes byte_budget (index 0) or entry_overhead (index 1) and is
// always ready; cmd takes add / lookup / clear operations; rsp returns the
// results, the final one of each operation marked with last. Every result of
// an operation carries the entry count and byte total left after it.
// cmd is ready only while no operation is in progress, one operation at a time.
// Entries live in one RAM with a registered read, walked one entry per cycle
// from the oldest (an emit step waits while the result register is full):
//   add, k evictions: a planning cost walk, k emitted evictions, a final result.
//   lookup: compares held entries until a hit or the last one, then a result.
//   clear: emits every held entry as an eviction, then a final result.
// The result register frees up as rsp transfers; when rsp stalls, an emit or
// final step holds in place and resumes with no loss.
// Reset empties the store and loads the register defaults; no clearing pass
// runs, since only held slots are ever read.
module fifo_store_byte_budget_lookup import fsbb_pkg::*; #(
	parameter int DEPTH    = 16,
	parameter int KEY_BITS = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	fsbb_cfg_if.sink     cfg,
	fsbb_cmd_if.sink     cmd,
	fsbb_rsp_if.source   rsp
);

	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int ENT_W = KEY_BITS + HANDLE_W + COST_W;

	state_t                state_q;
	logic [BUDGET_W-1:0]   budget_q;
	logic [OVH_W-1:0]      overhead_q;
	logic [AW-1:0]         oldest_q;
	logic [CW-1:0]         held_count_q;
	logic [BYTES_W-1:0]    held_bytes_q;

	logic [KEY_BITS-1:0]   key_q;
	logic [HANDLE_W-1:0]   handle_q;
	logic [COST_W-1:0]     cost_q;
	logic [CW-1:0]         fin_cnt_q;
	logic [BYTES_W-1:0]    fin_bytes_q;
	logic [CW-1:0]         rem_q;
	logic [AW-1:0]         ptr_q;
	logic [AW-1:0]         slot_q;
	logic [KIND_W-1:0]     res_kind_q;
	logic [HANDLE_W-1:0]   res_handle_q;

	logic                  out_valid_q;
	logic [KIND_W-1:0]     out_kind_q;
	logic [HANDLE_W-1:0]   out_handle_q;
	logic                  out_last_q;
	logic [CW-1:0]         out_cnt_q;
	logic [BYTES_W-1:0]    out_bytes_q;

	logic [AW-1:0]         ptr_d;
	logic [AW-1:0]         ptr_inc;
	logic                  cmd_xfer;
	logic                  out_free;
	logic [ENT_W-1:0]      rd_data;
	logic [ENT_W-1:0]      wr_data;
	logic                  wr_en;
	logic [KEY_BITS-1:0]   rd_key;
	logic [HANDLE_W-1:0]   rd_handle;
	logic [COST_W-1:0]     rd_cost;
	logic [BYTES_W:0]      plan_sum;
	logic                  plan_evict;
	logic [AW:0]           slot_sum;
	logic [AW-1:0]         slot_d;
	logic                  scan_hit;

	assign cfg.ready = 1'b1;
	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_xfer  = cmd.valid && cmd.ready;
	assign out_free  = !out_valid_q || rsp.ready;

	assign rsp.valid        = out_valid_q;
	assign rsp.kind         = out_kind_q;
	assign rsp.out_handle   = out_handle_q;
	assign rsp.last         = out_last_q;
	assign rsp.entries_held = ENTRIES_W'(out_cnt_q);
	assign rsp.bytes_held   = out_bytes_q;

	assign rd_key    = rd_data[ENT_W-1 -: KEY_BITS];
	assign rd_handle = rd_data[COST_W +: HANDLE_W];
	assign rd_cost   = rd_data[COST_W-1:0];

	assign ptr_inc = (ptr_q == AW'(DEPTH - 1)) ? '0 : ptr_q + 1'b1;

	// eviction test for the oldest entry still counted in the plan
	assign plan_sum   = {1'b0, fin_bytes_q} + (BYTES_W + 1)'(cost_q);
	assign plan_evict = (fin_cnt_q == CW'(DEPTH)) ||
		((fin_cnt_q != '0) && (plan_sum > (BYTES_W + 1)'(budget_q)));

	assign slot_sum = {1'b0, ptr_q} + (AW + 1)'(fin_cnt_q);
	assign slot_d   = (slot_sum >= (AW + 1)'(DEPTH)) ?
		AW'(slot_sum - (AW + 1)'(DEPTH)) : AW'(slot_sum);

	assign scan_hit = (rd_key == key_q);

	assign wr_en   = (state_q == ST_FINAL) && out_free && (res_kind_q == KIND_ADD_DONE);
	assign wr_data = {key_q, handle_q, cost_q};

	// read address is the pointer's next value, so rd_data always holds the
	// entry at ptr_q
	always_comb begin
		ptr_d = ptr_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_xfer) begin
					ptr_d = oldest_q;
				end
			end
			ST_PLAN: begin
				ptr_d = plan_evict ? ptr_inc : oldest_q;
			end
			ST_EMIT: begin
				if (out_free) begin
					ptr_d = ptr_inc;
				end
			end
			ST_SCAN: begin
				if (!scan_hit && rem_q != CW'(1)) begin
					ptr_d = ptr_inc;
				end
			end
			ST_FINAL: begin
				ptr_d = ptr_q;
			end
			default: begin
				ptr_d = ptr_q;
			end
		endcase
	end

	fsbb_ram #(
		.WIDTH(ENT_W),
		.DEPTH(DEPTH)
	) u_entry_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(slot_q),
		.wdata(wr_data),
		.raddr(ptr_d),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q   <= BUDGET_RST;
			overhead_q <= OVH_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_BYTE_BUDGET:    budget_q   <= cfg.data;
				REG_ENTRY_OVERHEAD: overhead_q <= cfg.data[OVH_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			oldest_q     <= '0;
			held_count_q <= '0;
			held_bytes_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_xfer) begin
						priority case (cmd.func)
							FUNC_ADD: begin
								state_q <= (cmd.handle == '0) ? ST_FINAL : ST_PLAN;
							end
							FUNC_LOOKUP: begin
								state_q <= (held_count_q == '0) ? ST_FINAL : ST_SCAN;
							end
							FUNC_CLEAR: begin
								state_q <= (held_count_q == '0) ? ST_FINAL : ST_EMIT;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_PLAN: begin
					if (!plan_evict) begin
						state_q <= (rem_q != '0) ? ST_EMIT : ST_FINAL;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (rem_q == CW'(1)) begin
							state_q <= ST_FINAL;
						end
					end
				end
				ST_SCAN: begin
					if (scan_hit || rem_q == CW'(1)) begin
						state_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
						if (res_kind_q == KIND_ADD_DONE) begin
							oldest_q     <= ptr_q;
							held_count_q <= fin_cnt_q;
							held_bytes_q <= fin_bytes_q;
						end else if (res_kind_q == KIND_CLEAR_DONE) begin
							oldest_q     <= '0;
							held_count_q <= '0;
							held_bytes_q <= '0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		ptr_q <= ptr_d;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_xfer) begin
					key_q        <= cmd.key[KEY_BITS-1:0];
					handle_q     <= cmd.handle;
					cost_q       <= COST_W'(cmd.size_bytes) + COST_W'(overhead_q);
					fin_cnt_q    <= held_count_q;
					fin_bytes_q  <= held_bytes_q;
					rem_q        <= '0;
					res_handle_q <= '0;
					priority case (cmd.func)
						FUNC_ADD: begin
							res_kind_q <= KIND_ADD_REJECT;
						end
						FUNC_LOOKUP: begin
							res_kind_q <= KIND_MISS;
							rem_q      <= held_count_q;
						end
						FUNC_CLEAR: begin
							res_kind_q  <= KIND_CLEAR_DONE;
							rem_q       <= held_count_q;
							fin_cnt_q   <= '0;
							fin_bytes_q <= '0;
						end
						default: begin
							res_kind_q <= KIND_MISS;
						end
					endcase
				end
			end
			ST_PLAN: begin
				if (plan_evict) begin
					fin_cnt_q   <= fin_cnt_q - 1'b1;
					fin_bytes_q <= fin_bytes_q - BYTES_W'(rd_cost);
					rem_q       <= rem_q + 1'b1;
				end else begin
					fin_cnt_q   <= fin_cnt_q + 1'b1;
					fin_bytes_q <= BYTES_W'(plan_sum);
					slot_q      <= slot_d;
					res_kind_q  <= KIND_ADD_DONE;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					out_kind_q   <= KIND_EVICT;
					out_handle_q <= rd_handle;
					out_last_q   <= 1'b0;
					out_cnt_q    <= fin_cnt_q;
					out_bytes_q  <= fin_bytes_q;
					rem_q        <= rem_q - 1'b1;
				end
			end
			ST_SCAN: begin
				if (scan_hit) begin
					res_kind_q   <= KIND_HIT;
					res_handle_q <= rd_handle;
				end else begin
					rem_q <= rem_q - 1'b1;
				end
			end
			ST_FINAL: begin
				if (out_free) begin
					out_kind_q   <= res_kind_q;
					out_handle_q <= res_handle_q;
					out_last_q   <= 1'b1;
					out_cnt_q    <= fin_cnt_q;
					out_bytes_q  <= fin_bytes_q;
				end
			end
			default: ;
		endcase
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_count_q <= CW'(DEPTH))
		else $error("held count exceeds depth");

	a_final_sends_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINAL) && out_free |=> rsp.valid && rsp.last)
		else $error("final result not presented with last");

	a_mid_is_evict: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.last |-> rsp.kind == KIND_EVICT)
		else $error("non-final result is not an evicted handle");

	a_emit_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) || (state_q == ST_SCAN) |-> rem_q != '0)
		else $error("walk running with nothing left");

	a_plan_returns_oldest: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PLAN) && !plan_evict |=> ptr_q == oldest_q)
		else $error("emit walk does not start at oldest entry");

endmodule
